@@ hdl/bmsi_pkg.sv @@
// shared types, codes and sizes for the bank mapper with scanline irq
// no dependencies; imported by every module of the block
package bmsi_pkg;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned OPCODE_W    = 3;
   localparam int unsigned MAPPED_W    = 21;
   localparam int unsigned OFFSET_W    = 13;
   localparam int unsigned CHR_OFF_W   = 10;
   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 9;
   localparam int unsigned REQ_DATA_W  = 32;
   localparam int unsigned RSP_DATA_W  = 32;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // opcodes on the request channel
   localparam logic [2:0] OP_WRITE = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_TICK  = 3'd2;
   localparam logic [2:0] OP_PRG   = 3'd3;
   localparam logic [2:0] OP_CHR   = 3'd4;

   // classified kinds handed from front to back
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_WRITE = 3'd1;
   localparam logic [2:0] KIND_READ  = 3'd2;
   localparam logic [2:0] KIND_TICK  = 3'd3;
   localparam logic [2:0] KIND_PRG   = 3'd4;
   localparam logic [2:0] KIND_CHR   = 3'd5;

   // register ports, {address[14:13], address[0]}
   localparam logic [2:0] REG_CTRL    = 3'd0;
   localparam logic [2:0] REG_BANK    = 3'd1;
   localparam logic [2:0] REG_MIRROR  = 3'd2;
   localparam logic [2:0] REG_PROTECT = 3'd3;
   localparam logic [2:0] REG_LATCH   = 3'd4;
   localparam logic [2:0] REG_RELOAD  = 3'd5;
   localparam logic [2:0] REG_IRQ_OFF = 3'd6;
   localparam logic [2:0] REG_IRQ_ON  = 3'd7;

   // bank data targets, control bits 2:0
   localparam logic [2:0] TGT_CHR_2K_A = 3'd0;
   localparam logic [2:0] TGT_CHR_2K_B = 3'd1;
   localparam logic [2:0] TGT_CHR_1K_4 = 3'd2;
   localparam logic [2:0] TGT_CHR_1K_5 = 3'd3;
   localparam logic [2:0] TGT_CHR_1K_6 = 3'd4;
   localparam logic [2:0] TGT_CHR_1K_7 = 3'd5;
   localparam logic [2:0] TGT_PRG_0    = 3'd6;
   localparam logic [2:0] TGT_PRG_1    = 3'd7;

   // configuration register indexes
   localparam logic [0:0] CSR_PRG_BANK_COUNT = 1'd0;
   localparam logic [0:0] CSR_FOUR_SCREEN    = 1'd1;

   localparam logic [COUNT_W-1:0] PRG_BANK_COUNT_RST = 9'd32;

   localparam int unsigned CTRL_PRG_MODE_BIT = 6;
   localparam int unsigned CTRL_CHR_MODE_BIT = 7;

   typedef struct packed {
      logic [2:0]          kind;
      logic [2:0]          idx;      // register index, prg slot in 2:1, or chr slot
      logic [OFFSET_W-1:0] offset;
      logic [BYTE_W-1:0]   data;
   } item_type;

   typedef struct packed {
      logic                irq_active;
      logic                mirror_horizontal;
      logic [MAPPED_W-1:0] mapped_address;
      logic [BYTE_W-1:0]   read_data;
   } result_type;

endpackage

@@ hdl/bmsi_front.sv @@
// front end: takes request beats, decodes opcode and address into an item
// depends on bmsi_pkg
module bmsi_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,
   output logic                fr_valid,
   input  logic                fr_ready,
   output bmsi_pkg::item_type  fr_item
);
   import bmsi_pkg::*;

   logic [OPCODE_W-1:0] opcode;
   logic [ADDR_W-1:0]   address;
   logic [BYTE_W-1:0]   data;
   logic                upper;
   item_type            item_in;
   item_type            item_ff;
   logic                valid_ff;
   logic                valid_in;
   logic                take;

   assign opcode  = req_tdata[2:0];
   assign address = req_tdata[18:3];
   assign data    = req_tdata[26:19];
   assign upper   = address[15];

   always_comb begin
      item_in.kind   = KIND_NONE;
      item_in.idx    = {address[14:13], address[0]};
      item_in.offset = address[OFFSET_W-1:0];
      item_in.data   = data;
      case (opcode)
         OP_WRITE: item_in.kind = upper ? KIND_WRITE : KIND_NONE;
         OP_READ:  item_in.kind = upper ? KIND_READ : KIND_NONE;
         OP_TICK:  item_in.kind = KIND_TICK;
         OP_PRG: begin
            item_in.kind = upper ? KIND_PRG : KIND_NONE;
            item_in.idx  = {address[14:13], 1'b0};
         end
         OP_CHR: begin
            item_in.kind = KIND_CHR;
            item_in.idx  = address[12:10];
         end
         default: item_in.kind = KIND_NONE;
      endcase
   end

   assign req_tready = !valid_ff || fr_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (fr_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign fr_valid = valid_ff;
   assign fr_item  = item_ff;

endmodule

@@ hdl/bmsi_queue.sv @@
// short fifo of decoded items between front and back
// depends on bmsi_pkg
module bmsi_queue #(
   parameter int unsigned DEPTH = bmsi_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   output logic                          push_ready,
   input  bmsi_pkg::item_type            push_item,
   output logic                          pop_valid,
   input  logic                          pop_ready,
   output bmsi_pkg::item_type            pop_item,
   output logic [$clog2(DEPTH+1)-1:0]    count
);
   import bmsi_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH-1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/bmsi_back.sv @@
// back end: mapper state, irq counter, translation and the result register
// depends on bmsi_pkg
module bmsi_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [bmsi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bmsi_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 bk_valid,
   output logic                                 bk_ready,
   input  bmsi_pkg::item_type                   bk_item,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output bmsi_pkg::result_type                 rsp_result
);
   import bmsi_pkg::*;

   logic [COUNT_W-1:0] bank_count_ff;
   logic               four_screen_ff;

   logic [BYTE_W-1:0] regs_ff [8];
   logic [BYTE_W-1:0] regs_in [8];
   logic [BYTE_W-1:0] chr_ff  [8];
   logic [BYTE_W-1:0] chr_in  [8];
   logic [BYTE_W-1:0] prg_ff  [2];
   logic [BYTE_W-1:0] prg_in  [2];
   logic [BYTE_W-1:0] counter_ff, counter_in;
   logic [BYTE_W-1:0] latch_ff, latch_in;
   logic              enabled_ff, enabled_in;
   logic              reload_ff, reload_in;
   logic              line_ff, line_in;
   logic              mirror_ff, mirror_in;

   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   logic              pop;
   logic              hit;
   logic [BYTE_W-1:0] dec;
   logic [BYTE_W-1:0] even;
   logic [BYTE_W-1:0] fixed_lo;
   logic [BYTE_W-1:0] fixed_hi;
   logic [BYTE_W-1:0] prg_bank;
   logic [1:0]        prg_slot;
   logic [2:0]        chr_slot;

   assign bk_ready = !out_valid_ff || rsp_tready;
   assign pop      = bk_valid && bk_ready;

   assign dec      = counter_ff - BYTE_W'(1);
   assign even     = {bk_item.data[BYTE_W-1:1], 1'b0};
   assign fixed_lo = bank_count_ff[BYTE_W-1:0] - BYTE_W'(2);
   assign fixed_hi = bank_count_ff[BYTE_W-1:0] - BYTE_W'(1);
   assign prg_slot = bk_item.idx[2:1];
   assign chr_slot = {bk_item.idx[2] ^ regs_ff[REG_CTRL][CTRL_CHR_MODE_BIT], bk_item.idx[1:0]};

   always_comb begin
      case (prg_slot)
         2'd0:    prg_bank = regs_ff[REG_CTRL][CTRL_PRG_MODE_BIT] ? fixed_lo : prg_ff[0];
         2'd1:    prg_bank = prg_ff[1];
         2'd2:    prg_bank = regs_ff[REG_CTRL][CTRL_PRG_MODE_BIT] ? prg_ff[0] : fixed_lo;
         default: prg_bank = fixed_hi;
      endcase
   end

   always_comb begin
      regs_in    = regs_ff;
      chr_in     = chr_ff;
      prg_in     = prg_ff;
      counter_in = counter_ff;
      latch_in   = latch_ff;
      enabled_in = enabled_ff;
      reload_in  = reload_ff;
      line_in    = line_ff;
      mirror_in  = mirror_ff;
      hit        = 1'b0;
      out_in.read_data      = '0;
      out_in.mapped_address = '0;

      case (bk_item.kind)
         KIND_WRITE: begin
            regs_in[bk_item.idx] = bk_item.data;
            case (bk_item.idx)
               REG_BANK: begin
                  // target comes from the control byte, untouched by this beat
                  case (regs_ff[REG_CTRL][2:0])
                     TGT_CHR_2K_A: begin
                        chr_in[0] = even;
                        chr_in[1] = even | BYTE_W'(1);
                     end
                     TGT_CHR_2K_B: begin
                        chr_in[2] = even;
                        chr_in[3] = even | BYTE_W'(1);
                     end
                     TGT_CHR_1K_4: chr_in[4] = bk_item.data;
                     TGT_CHR_1K_5: chr_in[5] = bk_item.data;
                     TGT_CHR_1K_6: chr_in[6] = bk_item.data;
                     TGT_CHR_1K_7: chr_in[7] = bk_item.data;
                     TGT_PRG_0:    prg_in[0] = bk_item.data;
                     default:      prg_in[1] = bk_item.data;
                  endcase
               end
               REG_MIRROR: begin
                  if (!four_screen_ff) begin
                     mirror_in = bk_item.data[0];
                  end
               end
               REG_LATCH:  latch_in  = bk_item.data;
               REG_RELOAD: reload_in = 1'b1;
               REG_IRQ_OFF: begin
                  enabled_in = 1'b0;
                  line_in    = 1'b0;
               end
               REG_IRQ_ON: enabled_in = 1'b1;
               default: ;
            endcase
         end
         KIND_READ: out_in.read_data = regs_ff[bk_item.idx];
         KIND_TICK: begin
            if (reload_ff) begin
               counter_in = latch_ff;
               reload_in  = 1'b0;
               hit        = (latch_ff == '0);
               line_in    = 1'b0;
            end else if (dec == '0) begin
               counter_in = latch_ff;
               hit        = 1'b1;
            end else begin
               counter_in = dec;
            end
            if (enabled_ff && hit) begin
               line_in = 1'b1;
            end
         end
         KIND_PRG: out_in.mapped_address = {prg_bank, bk_item.offset};
         KIND_CHR: out_in.mapped_address =
            {3'b000, chr_ff[chr_slot], bk_item.offset[CHR_OFF_W-1:0]};
         default: ;
      endcase

      out_in.mirror_horizontal = mirror_in;
      out_in.irq_active        = line_in;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_count_ff  <= PRG_BANK_COUNT_RST;
         four_screen_ff <= 1'b0;
         regs_ff        <= '{default: '0};
         chr_ff         <= '{default: '0};
         prg_ff         <= '{default: '0};
         counter_ff     <= '0;
         latch_ff       <= '0;
         enabled_ff     <= 1'b0;
         reload_ff      <= 1'b0;
         line_ff        <= 1'b0;
         mirror_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_PRG_BANK_COUNT: bank_count_ff  <= csr_wdata;
               CSR_FOUR_SCREEN:    four_screen_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (pop) begin
            regs_ff    <= regs_in;
            chr_ff     <= chr_in;
            prg_ff     <= prg_in;
            counter_ff <= counter_in;
            latch_ff   <= latch_in;
            enabled_ff <= enabled_in;
            reload_ff  <= reload_in;
            line_ff    <= line_in;
            mirror_ff  <= mirror_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

@@ hdl/bank_mapper_scanline_irq.sv @@
// Bank mapper with scanline irq counter. Every request beat (write, read,
// scanline tick, program or pattern translation) yields exactly one response
// beat carrying read data, the mapped rom address, the mirroring and the irq
// line level after that beat. The block takes one beat per clock unless
// stalled; a beat passes a decode register, a short item queue and the
// state/result register before its response is offered. The single shared
// state update in the back end sets the rate at one beat per cycle while
// responses are taken; the queue absorbs up to QUEUE_DEPTH beats while held
// off. The user must write csr configuration only while idle (not enforced).
// depends on bmsi_pkg, bmsi_front, bmsi_queue, bmsi_back
module bank_mapper_scanline_irq #(
   parameter int unsigned QUEUE_DEPTH = bmsi_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bmsi_pkg::REQ_DATA_W-1:0]   req_tdata,  // opcode, address, data
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_data, mapped_address, mirror_horizontal, irq_active
   output logic [bmsi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wen,
   input  logic [bmsi_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bmsi_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bmsi_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   logic             fr_valid;
   logic             fr_ready;
   item_type         fr_item;
   logic             bk_valid;
   logic             bk_ready;
   item_type         bk_item;
   logic [CNT_W-1:0] q_count;
   result_type       result;

   bmsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fr_valid   (fr_valid),
      .fr_ready   (fr_ready),
      .fr_item    (fr_item)
   );

   bmsi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_item  (fr_item),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_item   (bk_item),
      .count      (q_count)
   );

   bmsi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .bk_valid   (bk_valid),
      .bk_ready   (bk_ready),
      .bk_item    (bk_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {1'b0, result};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(QUEUE_DEPTH))
      else $error("item queue holds more than its depth");

   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(bk_valid))
      else $error("response appeared without a queued item");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (fr_valid && !fr_ready))
      else $error("request stalled while decode stage could advance");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

@@ tb/bank_mapper_scanline_irq_test.sv @@
// self-checking testbench for bank_mapper_scanline_irq: directed and random request beats
// against a cycle-free predictor of the mapper state, checked beat by beat on the response side
// depends on bmsi_pkg and the bank_mapper_scanline_irq top level
module bank_mapper_scanline_irq_test;
   import bmsi_pkg::*;

   // opcodes the block must treat as no-ops
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 210;

   class bank_map_tracker;
      logic [COUNT_W-1:0] bank_count;
      logic               four_screen;
      logic [7:0]         regs [8];
      logic [7:0]         chr_bank [8];
      logic [7:0]         prg_bank [2];
      logic [7:0]         counter;
      logic [7:0]         latch;
      logic               irq_on;
      logic               reload;
      logic               irq_line;
      logic               mirror;
      result_type         due [$];
      int unsigned        mismatches;

      function new();
         bank_count = PRG_BANK_COUNT_RST;
         four_screen = 1'b0;
         foreach (regs[i]) regs[i] = '0;
         foreach (chr_bank[i]) chr_bank[i] = '0;
         prg_bank[0] = '0;
         prg_bank[1] = '0;
         counter = '0;
         latch = '0;
         irq_on = 1'b0;
         reload = 1'b0;
         irq_line = 1'b0;
         mirror = 1'b0;
         mismatches = 0;
      endfunction

      function void set_config(logic [0:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_PRG_BANK_COUNT) begin
            bank_count = value;
         end else begin
            four_screen = value[0];
         end
      endfunction

      function void bus_write(logic [15:0] addr, logic [7:0] data);
         logic [2:0] sel;
         if (!addr[15]) return;
         sel = {addr[14:13], addr[0]};
         regs[sel] = data;
         case (sel)
            REG_BANK: begin
               case (regs[REG_CTRL][2:0])
                  TGT_CHR_2K_A: begin
                     chr_bank[0] = {data[7:1], 1'b0};
                     chr_bank[1] = {data[7:1], 1'b1};
                  end
                  TGT_CHR_2K_B: begin
                     chr_bank[2] = {data[7:1], 1'b0};
                     chr_bank[3] = {data[7:1], 1'b1};
                  end
                  TGT_CHR_1K_4: chr_bank[4] = data;
                  TGT_CHR_1K_5: chr_bank[5] = data;
                  TGT_CHR_1K_6: chr_bank[6] = data;
                  TGT_CHR_1K_7: chr_bank[7] = data;
                  TGT_PRG_0:    prg_bank[0] = data;
                  default:      prg_bank[1] = data;
               endcase
            end
            REG_MIRROR: if (!four_screen) mirror = data[0];
            REG_LATCH:  latch = data;
            REG_RELOAD: reload = 1'b1;
            REG_IRQ_OFF: begin
               irq_on = 1'b0;
               irq_line = 1'b0;
            end
            REG_IRQ_ON: irq_on = 1'b1;
            default: ;
         endcase
      endfunction

      function void scanline();
         logic hit;
         hit = 1'b0;
         if (reload) begin
            counter = latch;
            reload = 1'b0;
            hit = (counter == 8'd0);
            irq_line = 1'b0;
         end else begin
            counter = counter - 8'd1;
            if (counter == 8'd0) begin
               counter = latch;
               hit = 1'b1;
            end
         end
         if (irq_on && hit) irq_line = 1'b1;
      endfunction

      function logic [MAPPED_W-1:0] prg_rom_address(logic [15:0] addr);
         logic [7:0] bank;
         logic [7:0] fixed_lo;
         logic [7:0] fixed_hi;
         if (!addr[15]) return '0;
         // fixed windows wrap to the low 8 bank bits
         fixed_lo = 8'(bank_count - 9'd2);
         fixed_hi = 8'(bank_count - 9'd1);
         if (regs[REG_CTRL][CTRL_PRG_MODE_BIT]) begin
            case (addr[14:13])
               2'd0:    bank = fixed_lo;
               2'd1:    bank = prg_bank[1];
               2'd2:    bank = prg_bank[0];
               default: bank = fixed_hi;
            endcase
         end else begin
            case (addr[14:13])
               2'd0:    bank = prg_bank[0];
               2'd1:    bank = prg_bank[1];
               2'd2:    bank = fixed_lo;
               default: bank = fixed_hi;
            endcase
         end
         return {bank, addr[12:0]};
      endfunction

      function logic [MAPPED_W-1:0] chr_rom_address(logic [15:0] addr);
         logic [2:0] slot;
         slot = addr[12:10] ^ {regs[REG_CTRL][CTRL_CHR_MODE_BIT], 2'b00};
         return {3'b000, chr_bank[slot], addr[9:0]};
      endfunction

      function void note_request(logic [2:0] op, logic [15:0] addr, logic [7:0] data);
         result_type want;
         want = '0;
         case (op)
            OP_WRITE: bus_write(addr, data);
            OP_READ:  if (addr[15]) want.read_data = regs[{addr[14:13], addr[0]}];
            OP_TICK:  scanline();
            OP_PRG:   want.mapped_address = prg_rom_address(addr);
            OP_CHR:   want.mapped_address = chr_rom_address(addr);
            default: ;
         endcase
         want.mirror_horizontal = mirror;
         want.irq_active = irq_line;
         due.push_back(want);
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         mismatches++;
         $display("%0t %s: got %0h want %0h", $time, what, got, want);
      endtask

      task check_response(logic [RSP_DATA_W-1:0] tdata);
         result_type want;
         if (due.size() == 0) begin
            report("response beat with nothing outstanding", tdata, 0);
            return;
         end
         want = due.pop_front();
         if (tdata[7:0] !== want.read_data)
            report("read_data", tdata[7:0], want.read_data);
         if (tdata[28:8] !== want.mapped_address)
            report("mapped_address", tdata[28:8], want.mapped_address);
         if (tdata[29] !== want.mirror_horizontal)
            report("mirror_horizontal", tdata[29], want.mirror_horizontal);
         if (tdata[30] !== want.irq_active)
            report("irq_active", tdata[30], want.irq_active);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // opcode, address, data
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // read_data, mapped_address, mirror_horizontal, irq_active
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bank_map_tracker tracker = new();
   int unsigned     items_sent;
   int unsigned     send_gap_pct;
   int unsigned     recv_stall_pct;
   bit              pressure_request;
   bit              pressure_given;
   int unsigned     quiet_cycles;

   bank_mapper_scanline_irq dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // both channels observed at the edge, before any update of this step lands
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            tracker.note_request(req_tdata[2:0], req_tdata[18:3], req_tdata[26:19]);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (pressure_request) begin
            rsp_tready <= 1'b0;
            pressure_request = 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [15:0] port_address(logic [2:0] sel);
      return {1'b1, sel[2:1], 12'($urandom), sel[0]};
   endfunction

   task automatic send_item(logic [2:0] op, logic [15:0] addr, logic [7:0] data);
      if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b00000, data, addr, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_single();
      int unsigned pick;
      logic [2:0]  op;
      logic [15:0] addr;
      logic [7:0]  data;
      pick = $urandom_range(1, 100);
      addr = 16'($urandom);
      data = 8'($urandom);
      if (pick <= 30) begin
         op = OP_WRITE;
         addr = port_address(3'($urandom));
      end else if (pick <= 40) begin
         op = OP_READ;
         if ($urandom_range(0, 9) != 0) addr = port_address(3'($urandom));
      end else if (pick <= 60) begin
         op = OP_TICK;
      end else if (pick <= 75) begin
         op = OP_PRG;
         if ($urandom_range(0, 9) != 0) addr[15] = 1'b1;
      end else if (pick <= 90) begin
         op = OP_CHR;
      end else if (pick <= 93) begin
         op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end else begin
         op = 3'($urandom);
      end
      send_item(op, addr, data);
   endtask

   // select a target, load it, then translate through it
   task automatic bank_sequence();
      int unsigned n;
      send_item(OP_WRITE, port_address(REG_CTRL), 8'($urandom));
      send_item(OP_WRITE, port_address(REG_BANK), 8'($urandom));
      n = $urandom_range(1, 4);
      repeat (n) begin
         if ($urandom_range(0, 1) == 0) begin
            send_item(OP_PRG, {1'b1, 15'($urandom)}, 8'($urandom));
         end else begin
            send_item(OP_CHR, 16'($urandom), 8'($urandom));
         end
      end
   endtask

   // program the scanline counter, then run ticks with a little noise between
   task automatic irq_sequence();
      logic [7:0]  latch_value;
      int unsigned n;
      latch_value = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
      send_item(OP_WRITE, port_address(REG_LATCH), latch_value);
      if ($urandom_range(0, 3) != 0) send_item(OP_WRITE, port_address(REG_RELOAD), 8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         send_item(OP_WRITE, port_address(REG_IRQ_OFF), 8'($urandom));
      end else begin
         send_item(OP_WRITE, port_address(REG_IRQ_ON), 8'($urandom));
      end
      n = $urandom_range(1, 12);
      repeat (n) begin
         if ($urandom_range(0, 5) == 0) begin
            send_single();
         end else begin
            send_item(OP_TICK, 16'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_config(idx, value);
   endtask

   task automatic directed_items();
      send_item(OP_READ, 16'h8000, 8'h00);
      send_item(OP_PRG, 16'h8000, 8'h00);
      send_item(OP_PRG, 16'hFFFF, 8'h00);
      // pattern address with high bits set
      send_item(OP_CHR, 16'hFFFF, 8'hFF);
      // low addresses: write dropped, read and translate give zero
      send_item(OP_WRITE, 16'h7FFF, 8'hFF);
      send_item(OP_READ, 16'h7FFF, 8'h00);
      send_item(OP_PRG, 16'h7FFF, 8'h00);
      send_item(OP_WRITE, 16'h8000, 8'hC6);
      send_item(OP_WRITE, 16'h8001, 8'hFF);
      send_item(OP_PRG, 16'h8000, 8'h00);
      send_item(OP_PRG, 16'hC123, 8'h00);
      // 2k pair forced even with odd partner
      send_item(OP_WRITE, 16'h8000, 8'hC0);
      send_item(OP_WRITE, 16'h9FFF, 8'hFF);
      send_item(OP_CHR, 16'h17FF, 8'h00);
      send_item(OP_WRITE, 16'hA000, 8'h01);
      send_item(OP_WRITE, 16'hA001, 8'h55);
      send_item(OP_READ, 16'hBFFF, 8'h00);
      // zero latch reload hits at once, then the counter wraps without a hit
      send_item(OP_WRITE, 16'hC000, 8'h00);
      send_item(OP_WRITE, 16'hC001, 8'h00);
      send_item(OP_WRITE, 16'hE001, 8'h00);
      send_item(OP_TICK, 16'h0000, 8'h00);
      send_item(OP_TICK, 16'hFFFF, 8'hFF);
      send_item(OP_WRITE, 16'hE000, 8'h00);
      send_item(OP_SPARE_LO, 16'hFFFF, 8'hFF);
      send_item(OP_SPARE_HI, 16'hFFFF, 8'hFF);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] counts [PHASES];
      logic                  fours [PHASES];
      int unsigned           phase_start;
      counts = '{9'd32, 9'd2, 9'd256, 9'd0, 9'd511, 9'd1, 9'd300, 9'd32};
      fours = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      items_sent = 0;
      quiet_cycles = 0;
      pressure_request = 1'b0;
      pressure_given = 1'b0;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_wen <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int unsigned p = 0; p < PHASES; p++) begin
         req_tvalid <= 1'b0;
         // let the monitor note the last accepted beat before draining
         @(posedge clock);
         while (tracker.due.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         if (p == PHASES - 1) begin
            counts[p] = 9'($urandom_range(2, 256));
            fours[p] = 1'($urandom);
         end
         write_csr(CSR_PRG_BANK_COUNT, counts[p]);
         write_csr(CSR_FOUR_SCREEN, CSR_DATA_W'(fours[p]));
         csr_wen <= 1'b0;
         // no idling in the second phase, during the hold-off, and at the end
         if (p == 1 || p == 2 || p == PHASES - 1) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end else begin
            send_gap_pct = $urandom_range(2, 15);
            recv_stall_pct = $urandom_range(2, 15);
         end
         if (p == 0) directed_items();
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (p == 2 && !pressure_given && items_sent - phase_start >= 50) begin
               pressure_request = 1'b1;
               pressure_given = 1'b1;
            end
            case ($urandom_range(0, 9))
               0, 1, 2:    bank_sequence();
               3, 4:       irq_sequence();
               default:    send_single();
            endcase
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
